>>> rtl/osat_pkg.sv
// Shared types and constants for the obstacle summed-area table.
// Used by the channel interfaces, the line store and the top level.
// No dependencies.
`timescale 1ns / 1ps

package osat_pkg;

  // Map geometry
  localparam int MAX_ROW_WIDTH = 1024;
  localparam int COL_W         = $clog2(MAX_ROW_WIDTH);   // column address
  localparam int WIDTH_W       = 11;                      // row_width register
  localparam int RUN_W         = $clog2(MAX_ROW_WIDTH + 1);
  localparam int CHAR_W        = 8;
  localparam int COUNT_W       = 21;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = COUNT_W'(1048576);
  localparam logic [RUN_W-1:0]   RUN_LIMIT     = RUN_W'(MAX_ROW_WIDTH);
  localparam logic [WIDTH_W-1:0] WIDTH_LIMIT   = WIDTH_W'(MAX_ROW_WIDTH);

  // Register reset values
  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RST = WIDTH_W'(1);
  localparam logic [CHAR_W-1:0]  OBST_RST      = CHAR_W'(111);
  localparam logic [CHAR_W-1:0]  EMPTY_RST     = CHAR_W'(46);

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = WIDTH_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_WIDTH     = 2'd0,
    REG_OBSTACLE_CHAR = 2'd1,
    REG_EMPTY_CHAR    = 2'd2
  } cfg_reg_t;

  // Write port of the line store
  typedef struct packed {
    logic               en;
    logic [COL_W-1:0]   addr;
    logic [COUNT_W-1:0] data;
  } ls_wr_t;

endpackage

>>> rtl/osat_if.sv
// Channel interfaces for the obstacle summed-area table: cell input,
// count output and configuration writes.
// Depends on osat_pkg.
`timescale 1ns / 1ps

interface osat_in_if
  import osat_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] cell_char;
  logic              new_map;

  modport source (output valid, cell_char, new_map, input ready);
  modport sink   (input valid, cell_char, new_map, output ready);
endinterface

interface osat_out_if
  import osat_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] obstacle_count;
  logic               bad_char;

  modport source (output valid, obstacle_count, bad_char, input ready);
  modport sink   (input valid, obstacle_count, bad_char, output ready);
endinterface

interface osat_cfg_if
  import osat_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/osat_line_store.sv
// Line store holding the summed-area values of the row above.
// One write and one read port, registered read data. Depends on osat_pkg.
`timescale 1ns / 1ps

module osat_line_store
  import osat_pkg::*;
(
  input  logic               clk,
  input  ls_wr_t             wr,
  input  logic               rd_en,
  input  logic [COL_W-1:0]   rd_addr,
  output logic [COUNT_W-1:0] rd_data
);

  logic [COUNT_W-1:0] mem [MAX_ROW_WIDTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/obstacle_summed_area_table.sv
// Obstacle summed-area table: top level with row tracking, count pipeline
// and output register. Depends on osat_pkg, osat_if and osat_line_store.
//
// Takes one map cell per clock, unless the output stalls, and returns, for each
// cell, the number of obstacle cells between the map origin and that cell. The
// above-row sum of an accepted cell is read from the line store into stage 1,
// and its result enters the output register when stage 1 moves on; the single
// line-store read port per cell sets that rate. A cell that reads the column
// just written by its predecessor takes the forwarded sum. The line store needs
// no clearing after reset: the first row of each map never uses it. Register
// writes are always accepted and should be made while no cell is in flight.
`timescale 1ns / 1ps

module obstacle_summed_area_table
  import osat_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  osat_in_if.sink      in_if,
  osat_out_if.source   out_if,
  osat_cfg_if.sink     cfg_if
);

  // Configuration registers
  logic [WIDTH_W-1:0] row_width_r;
  logic [CHAR_W-1:0]  obst_char_r;
  logic [CHAR_W-1:0]  empty_char_r;

  // Row tracking state
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [RUN_W-1:0]   run_r, run_nxt;
  logic               first_row_r, first_row_nxt;
  logic [WIDTH_W-1:0] cols_wr_r, cols_wr_nxt;

  // Stage 1 (line-store read returned)
  logic               s1_valid_r;
  logic [COL_W-1:0]   s1_addr_r;
  logic [RUN_W-1:0]   s1_run_r;
  logic               s1_use_above_r;
  logic               s1_bad_r;
  logic               s1_fwd_r;
  logic [COUNT_W-1:0] s1_fwd_data_r;

  // Output register
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_bad_r;

  logic               in_acc;
  logic               s1_move;
  logic [WIDTH_W-1:0] eff_width;
  logic [COUNT_W-1:0] rd_data;
  logic [COUNT_W-1:0] above;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] count;
  logic               is_obst;
  logic               bad;
  logic               use_above;
  logic [COL_W-1:0]   cell_col;
  logic [WIDTH_W-1:0] col_inc;
  ls_wr_t             ls_wr;

  // Configuration port
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r  <= ROW_WIDTH_RST;
      obst_char_r  <= OBST_RST;
      empty_char_r <= EMPTY_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_ROW_WIDTH:     row_width_r  <= cfg_if.data;
        REG_OBSTACLE_CHAR: obst_char_r  <= cfg_if.data[CHAR_W-1:0];
        REG_EMPTY_CHAR:    empty_char_r <= cfg_if.data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Width clamped to 1..MAX_ROW_WIDTH
  always_comb begin
    if (row_width_r == '0) begin
      eff_width = WIDTH_W'(1);
    end else if (row_width_r > WIDTH_LIMIT) begin
      eff_width = WIDTH_LIMIT;
    end else begin
      eff_width = row_width_r;
    end
  end

  // Handshakes
  assign s1_move     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_move;
  assign in_acc      = in_if.valid && in_if.ready;

  // Row tracking for the accepted cell
  always_comb begin
    col_nxt       = col_r;
    run_nxt       = run_r;
    first_row_nxt = first_row_r;
    cols_wr_nxt   = cols_wr_r;

    if (in_if.new_map) begin
      col_nxt       = '0;
      run_nxt       = '0;
      first_row_nxt = 1'b1;
      cols_wr_nxt   = '0;
    end
    // width lowered mid-row: close the row before this cell
    if (WIDTH_W'(col_nxt) >= eff_width) begin
      col_nxt       = '0;
      run_nxt       = '0;
      first_row_nxt = 1'b0;
    end

    cell_col  = col_nxt;
    is_obst   = (in_if.cell_char == obst_char_r);
    bad       = !is_obst && (in_if.cell_char != empty_char_r);
    use_above = !first_row_nxt && (WIDTH_W'(cell_col) < cols_wr_nxt);

    if (run_nxt < RUN_LIMIT) begin
      run_nxt = run_nxt + RUN_W'(is_obst);
    end
    if (WIDTH_W'(cell_col) >= cols_wr_nxt) begin
      cols_wr_nxt = WIDTH_W'(cell_col) + WIDTH_W'(1);
    end

    col_inc = WIDTH_W'(cell_col) + WIDTH_W'(1);
    col_nxt = col_inc[COL_W-1:0];
  end

  // Row state register; end-of-row close is folded in on update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      run_r       <= '0;
      first_row_r <= 1'b1;
      cols_wr_r   <= '0;
    end else if (in_acc) begin
      cols_wr_r <= cols_wr_nxt;
      if (col_inc >= eff_width) begin
        col_r       <= '0;
        run_r       <= '0;
        first_row_r <= 1'b0;
      end else begin
        col_r       <= col_nxt;
        run_r       <= run_nxt;
        first_row_r <= first_row_nxt;
      end
    end
  end

  // Stage 1 count with saturation
  assign above = !s1_use_above_r ? '0 : (s1_fwd_r ? s1_fwd_data_r : rd_data);
  assign sum   = {1'b0, above} + (COUNT_W + 1)'(s1_run_r);
  assign count = (sum > (COUNT_W + 1)'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];

  // Write back the new sum for this column
  always_comb begin
    ls_wr.en   = s1_move;
    ls_wr.addr = s1_addr_r;
    ls_wr.data = count;
  end

  osat_line_store u_line_store (
    .clk     (clk),
    .wr      (ls_wr),
    .rd_en   (in_acc),
    .rd_addr (cell_col),
    .rd_data (rd_data)
  );

  // Stage 1 register, with forwarding from the cell leaving stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr_r      <= cell_col;
      s1_run_r       <= run_nxt;
      s1_use_above_r <= use_above;
      s1_bad_r       <= bad;
      s1_fwd_r       <= s1_move && (s1_addr_r == cell_col);
      s1_fwd_data_r  <= count;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_count_r <= count;
      out_bad_r   <= s1_bad_r;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.obstacle_count = out_count_r;
  assign out_if.bad_char       = out_bad_r;

endmodule

>>> bench/obstacle_summed_area_table_test.sv
// Self-checking bench for obstacle_summed_area_table: streams map cells, predicts
// every obstacle count and compares it with the result channel.
// Depends on osat_pkg, the osat channel interfaces and the top level.
`timescale 1ns / 1ps

module obstacle_summed_area_table_test;
  import osat_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic              new_map;
  } cell_t;

  typedef struct packed {
    logic [COUNT_W-1:0] obstacle_count;
    logic               bad_char;
  } count_t;

  logic clk = 1'b0;
  logic rst_n;

  osat_in_if  in_ch ();
  osat_out_if out_ch ();
  osat_cfg_if cfg_ch ();

  obstacle_summed_area_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Clock, 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stimulus and scoreboard storage
  cell_t  cell_queue[$];
  count_t expected_counts[$];
  cell_t  offered_cell;

  // Predictor state: line store, row tracking and register copies
  logic [COUNT_W-1:0] line_sums [MAX_ROW_WIDTH];
  int unsigned        run_sum;
  int unsigned        col_idx;
  int unsigned        cols_written;
  bit                 first_row;
  logic [WIDTH_W-1:0] cur_row_width;
  logic [CHAR_W-1:0]  cur_obst_char;
  logic [CHAR_W-1:0]  cur_empty_char;

  // Idling and pressure controls
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          send_hold      = 1'b0;
  bit          rx_hold_req    = 1'b0;
  bit          rx_hold_seen   = 1'b0;
  int unsigned rx_hold_left   = 0;
  bit          force_new_map  = 1'b0;

  int unsigned fail_count      = 0;
  int unsigned cells_accepted  = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used   = 0;
  count_t      want;

  function automatic int unsigned eff_width(logic [WIDTH_W-1:0] w);
    if (w == '0) return 1;
    if (w > WIDTH_LIMIT) return MAX_ROW_WIDTH;
    return w;
  endfunction

  function automatic void close_row();
    col_idx   = 0;
    run_sum   = 0;
    first_row = 1'b0;
  endfunction

  // Summed-area prediction for one accepted cell; updates the predictor state
  function automatic count_t predict_count(cell_t c);
    int unsigned w;
    int unsigned above;
    int unsigned total;
    bit          obst;
    count_t      r;
    w = eff_width(cur_row_width);
    if (c.new_map) begin
      run_sum      = 0;
      col_idx      = 0;
      first_row    = 1'b1;
      cols_written = 0;
    end
    if (col_idx >= w) close_row();
    obst       = (c.cell_char == cur_obst_char);
    r.bad_char = !obst && (c.cell_char != cur_empty_char);
    // running count is capped at one full row
    if (run_sum < MAX_ROW_WIDTH) run_sum += obst;
    above = 0;
    if (!first_row && col_idx < cols_written) above = line_sums[col_idx];
    total = above + run_sum;
    if (total > COUNT_MAX) total = COUNT_MAX;
    line_sums[col_idx] = COUNT_W'(total);
    if (col_idx >= cols_written) cols_written = col_idx + 1;
    col_idx++;
    if (col_idx >= w) close_row();
    r.obstacle_count = COUNT_W'(total);
    return r;
  endfunction

  // Driver: offers queued cells, predicts on each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.cell_char <= '0;
      in_ch.new_map   <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_counts.push_back(predict_count(offered_cell));
        cells_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (cell_queue.size() > 0 && !send_hold &&
            $urandom_range(99) >= send_idle_pct) begin
          offered_cell     = cell_queue.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.cell_char <= offered_cell.cell_char;
          in_ch.new_map   <= offered_cell.new_map;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_counts.size() == 0) begin
          $error("result with no prediction waiting: count %0d bad %0d",
                 out_ch.obstacle_count, out_ch.bad_char);
          fail_count++;
        end else begin
          want = expected_counts.pop_front();
          results_checked++;
          if (out_ch.obstacle_count !== want.obstacle_count) begin
            $error("obstacle_count mismatch: expected %0d, actual %0d",
                   want.obstacle_count, out_ch.obstacle_count);
            fail_count++;
          end
          if (out_ch.bad_char !== want.bad_char) begin
            $error("bad_char mismatch: expected %0d, actual %0d",
                   want.bad_char, out_ch.bad_char);
            fail_count++;
          end
        end
      end
      // long hold-off requested by toggling rx_hold_req
      if (rx_hold_req != rx_hold_seen) begin
        rx_hold_seen = rx_hold_req;
        rx_hold_left = 80;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Register write; the block is idle whenever this is called
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    int unsigned old_w;
    old_w = eff_width(cur_row_width);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_ROW_WIDTH: begin
        cur_row_width = val;
        // a wider row restarts the map
        if (eff_width(val) > old_w) force_new_map = 1'b1;
      end
      REG_OBSTACLE_CHAR: cur_obst_char  = val[CHAR_W-1:0];
      REG_EMPTY_CHAR:    cur_empty_char = val[CHAR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_cell(logic [CHAR_W-1:0] ch, logic nm);
    cell_queue.push_back('{cell_char: ch, new_map: nm | force_new_map});
    force_new_map = 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (cell_queue.size() > 0 || in_ch.valid || expected_counts.size() > 0);
    repeat (4) @(negedge clk);
  endtask

  // Random map content: mostly obstacle or empty cells, some stray bytes
  task automatic stream_map_cells(int unsigned n, bit random_restart, bit pressure);
    int unsigned pick;
    logic [CHAR_W-1:0] ch;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 45)      ch = cur_obst_char;
      else if (pick < 90) ch = cur_empty_char;
      else                ch = CHAR_W'($urandom_range(255));
      queue_cell(ch, random_restart && ($urandom_range(199) == 0));
    end
    if (pressure) begin
      while (cell_queue.size() > n / 2) @(negedge clk);
      rx_hold_req = ~rx_hold_req;
      while (cell_queue.size() > n / 4) @(negedge clk);
      send_hold = 1'b1;
      while (in_ch.valid || expected_counts.size() > 0) @(negedge clk);
      send_hold = 1'b0;
    end
  endtask

  // Main sequence
  initial begin
    logic [WIDTH_W-1:0] phase_widths [10];
    logic [CHAR_W-1:0]  obst;
    logic [CHAR_W-1:0]  empt;
    int unsigned        n;
    phase_widths = '{11'd3, 11'd0, 11'd16, 11'd5, 11'd1024,
                     11'd2047, 11'd1, 11'd9, 11'd2, 11'd31};

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cell_char = '0;
    in_ch.new_map   = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_ROW_WIDTH;
    cfg_ch.data     = '0;

    cur_row_width  = ROW_WIDTH_RST;
    cur_obst_char  = OBST_RST;
    cur_empty_char = EMPTY_RST;
    run_sum        = 0;
    col_idx        = 0;
    cols_written   = 0;
    first_row      = 1'b1;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, no restart flag yet: stream counts as begun at reset
    @(negedge clk);
    queue_cell(OBST_RST, 1'b0);
    queue_cell(EMPTY_RST, 1'b0);
    queue_cell(OBST_RST, 1'b0);
    queue_cell(8'h78, 1'b0);
    queue_cell(8'h00, 1'b0);
    queue_cell(8'hFF, 1'b0);
    wait_drained();
    settings_used++;

    // 4-wide map of two rows; the wider row restarts the map
    write_reg(REG_ROW_WIDTH, 11'd4);
    @(negedge clk);
    queue_cell(OBST_RST, 1'b0);
    queue_cell(EMPTY_RST, 1'b0);
    queue_cell(OBST_RST, 1'b0);
    queue_cell(EMPTY_RST, 1'b0);
    queue_cell(EMPTY_RST, 1'b0);
    queue_cell(OBST_RST, 1'b0);
    queue_cell(OBST_RST, 1'b0);
    queue_cell(EMPTY_RST, 1'b0);
    wait_drained();
    settings_used++;

    // Obstacle code equal to empty code: such cells count as obstacles
    write_reg(REG_OBSTACLE_CHAR, {3'b000, EMPTY_RST});
    @(negedge clk);
    queue_cell(EMPTY_RST, 1'b0);
    queue_cell(OBST_RST, 1'b0);
    queue_cell(EMPTY_RST, 1'b0);
    wait_drained();
    settings_used++;

    // Width lowered mid-row: the open row closes before the next cell
    write_reg(REG_OBSTACLE_CHAR, {3'b000, OBST_RST});
    write_reg(REG_ROW_WIDTH, 11'd2);
    @(negedge clk);
    queue_cell(OBST_RST, 1'b0);
    queue_cell(OBST_RST, 1'b0);
    queue_cell(EMPTY_RST, 1'b1);
    wait_drained();
    settings_used++;

    // Random phases over a spread of widths and character codes
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin
          obst = 8'h00;
          empt = 8'hFF;
        end
        1: begin
          obst = 8'hFF;
          empt = 8'h00;
        end
        default: begin
          obst = CHAR_W'($urandom_range(255));
          empt = CHAR_W'($urandom_range(255));
        end
      endcase
      write_reg(REG_ROW_WIDTH, phase_widths[p]);
      write_reg(REG_OBSTACLE_CHAR, {3'b000, obst});
      write_reg(REG_EMPTY_CHAR, {3'b000, empt});
      settings_used++;
      @(negedge clk);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 69;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 69;
        end
        default: begin
          send_idle_pct  = 30;
          recv_stall_pct = 30;
        end
      endcase
      // the two wide phases share one map and fill about half a full-width row
      if (eff_width(phase_widths[p]) >= MAX_ROW_WIDTH) n = 250;
      else if (p == 2) n = 120;
      else n = 30;
      stream_map_cells(n, eff_width(phase_widths[p]) < MAX_ROW_WIDTH, p == 2);
      wait_drained();
    end

    // Final drain with a bound, then leftover check
    for (int i = 0; i < 2000 && (expected_counts.size() > 0 || in_ch.valid); i++)
      @(negedge clk);
    repeat (8) @(negedge clk);
    if (expected_counts.size() > 0) begin
      $error("%0d predicted results never arrived", expected_counts.size());
      fail_count++;
    end

    $display("Streamed %0d map cells under %0d register settings, %0d results checked",
             cells_accepted, settings_used, results_checked);
    $display("Widths 0 to 2047, codes 0 and 255, restarts, lowered width, long stalls");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/osat_pkg.sv
rtl/osat_if.sv
rtl/osat_line_store.sv
rtl/obstacle_summed_area_table.sv
bench/obstacle_summed_area_table_test.sv
